/* rtl/core/twsmb_pkg.sv */
// Package for the three-wire serial bus master with BCD conversion.
// Holds the command codes, the BCD constants and the result beat type.
// No dependencies.
package twsmb_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_BURST = 2'd3;

    localparam logic [6:0] BCD_MAX   = 7'd99;
    localparam logic [7:0] DIV10_MUL = 8'd205;
    localparam int         DIV10_SHR = 11;
    localparam logic [6:0] BYTE_BITS = 7'd8;

    typedef struct packed {
        logic        chip_enable;
        logic        serial_clock;
        logic        data_pin_out;
        logic        data_drive;
        logic        busy_res;
        logic        done_res;
        logic [7:0]  read_value;
        logic [63:0] read_raw;
    } res_t;

endpackage

/* rtl/core/three_wire_serial_master_bcd.sv */
// Top level of the three-wire serial bus master with BCD conversion.
// Depends on twsmb_pkg.
//
// Usage: every input beat is one pin-level tick of the serial bus. It carries
// an optional command (single read, write, burst read), the command address,
// the decimal write value and the sampled data pin. Each accepted input beat
// produces exactly one result beat with the pin levels for that tick, the
// busy and done flags, and on the done tick the decoded read byte or the raw
// burst bits. A command raises chip enable and shifts the command byte out
// LSB first, two ticks per bit; a write adds the value as BCD, a read samples
// 8 bits, a burst BURST_BITS bits. Commands arriving while busy are ignored.
// The result beat is registered; one beat is taken every cycle while the skid
// register is empty. Bus state and result are computed in a single pass
// between the state registers and the result register. A two-entry output
// stage (result register plus skid register) keeps the input open for one
// more beat while the receiver stalls; the input then closes until the skid
// entry drains. Reset empties the output stage and returns the bus state to
// idle, so the first transfer after reset starts from chip enable low; the
// result pins are only meaningful while out_valid is high.
module three_wire_serial_master_bcd #(
    parameter int BURST_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  address,
    input  logic [6:0]  write_data,
    input  logic        data_pin_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        chip_enable,
    output logic        serial_clock,
    output logic        data_pin_out,
    output logic        data_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_value,
    output logic [63:0] read_raw
);
    import twsmb_pkg::*;

    localparam int         IDX_W     = (BURST_BITS > 1) ? $clog2(BURST_BITS) : 1;
    localparam logic [6:0] BURST_LEN = 7'(BURST_BITS);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CMD    = 3'd1;
    localparam logic [2:0] PH_WDATA  = 3'd2;
    localparam logic [2:0] PH_READ   = 3'd3;
    localparam logic [2:0] PH_FINISH = 3'd4;

    logic [2:0]            phase_reg, phase_next;
    logic [6:0]            bit_count_reg, bit_count_next;
    logic                  clock_level_reg, clock_level_next;
    logic [15:0]           out_shift_reg, out_shift_next;
    logic [BURST_BITS-1:0] in_shift_reg, in_shift_next;
    logic [1:0]            kind_reg, kind_next;

    res_t res_next;
    res_t res_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic in_acc;

    logic [6:0]  wsat;
    logic [14:0] wprod;
    logic [3:0]  wtens;
    logic [3:0]  wones;
    logic [7:0]  cmd_byte;
    logic [7:0]  rbyte;
    logic [6:0]  total;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        wsat  = (write_data > BCD_MAX) ? BCD_MAX : write_data;
        wprod = 15'(wsat) * 15'(DIV10_MUL);
        wtens = 4'(wprod >> DIV10_SHR);
        wones = 4'(wsat - 7'(wtens) * 7'd10);
        cmd_byte = (op == OP_READ) ? address + 8'd1 : address;
        rbyte = in_shift_reg[7:0];
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        clock_level_next = clock_level_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        kind_next        = kind_reg;
        res_next         = '0;

        if (phase_reg == PH_IDLE || phase_reg > PH_FINISH)
        begin
            phase_next = PH_IDLE;
            if (op != OP_TICK)
            begin
                kind_next        = op;
                out_shift_next   = (op == OP_WRITE) ? {wtens, wones, cmd_byte}
                                                    : {8'd0, cmd_byte};
                bit_count_next   = '0;
                clock_level_next = 1'b0;
                in_shift_next    = '0;
                phase_next       = PH_CMD;
            end
        end

        total = (kind_next == OP_BURST) ? BURST_LEN : BYTE_BITS;

        unique case (phase_next)
            PH_CMD, PH_WDATA:
            begin
                res_next.chip_enable  = 1'b1;
                res_next.data_drive   = 1'b1;
                res_next.busy_res     = 1'b1;
                res_next.data_pin_out = out_shift_next[0];
                if (!clock_level_next)
                begin
                    clock_level_next = 1'b1;
                end
                else
                begin
                    res_next.serial_clock = 1'b1;
                    out_shift_next        = out_shift_next >> 1;
                    clock_level_next      = 1'b0;
                    if (bit_count_next + 7'd1 >= BYTE_BITS)
                    begin
                        bit_count_next = '0;
                        if (phase_next == PH_WDATA)
                        begin
                            phase_next = PH_FINISH;
                        end
                        else if (kind_next == OP_WRITE)
                        begin
                            phase_next = PH_WDATA;
                        end
                        else
                        begin
                            phase_next    = PH_READ;
                            in_shift_next = '0;
                        end
                    end
                    else
                    begin
                        bit_count_next = bit_count_next + 7'd1;
                    end
                end
            end
            PH_READ:
            begin
                res_next.chip_enable = 1'b1;
                res_next.busy_res    = 1'b1;
                if (!clock_level_next)
                begin
                    if (data_pin_in)
                    begin
                        in_shift_next[bit_count_next[IDX_W-1:0]] = 1'b1;
                    end
                    if (bit_count_next + 7'd1 >= total)
                    begin
                        phase_next = PH_FINISH;
                    end
                    else
                    begin
                        clock_level_next = 1'b1;
                    end
                end
                else
                begin
                    res_next.serial_clock = 1'b1;
                    bit_count_next        = bit_count_next + 7'd1;
                    clock_level_next      = 1'b0;
                end
            end
            PH_FINISH:
            begin
                res_next.done_res = 1'b1;
                if (kind_next == OP_READ)
                begin
                    res_next.read_value = {1'b0, rbyte[7:4], 3'b000}
                                        + {3'b000, rbyte[7:4], 1'b0}
                                        + {4'd0, rbyte[3:0]};
                end
                else if (kind_next == OP_BURST)
                begin
                    res_next.read_raw = 64'(in_shift_next);
                end
                phase_next       = PH_IDLE;
                bit_count_next   = '0;
                clock_level_next = 1'b0;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            clock_level_reg <= 1'b0;
            out_shift_reg   <= '0;
            in_shift_reg    <= '0;
            kind_reg        <= OP_TICK;
        end
        else if (in_acc)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            clock_level_reg <= clock_level_next;
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            kind_reg        <= kind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                res_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                res_reg <= res_next;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_enable  = res_reg.chip_enable;
    assign serial_clock = res_reg.serial_clock;
    assign data_pin_out = res_reg.data_pin_out;
    assign data_drive   = res_reg.data_drive;
    assign busy_res     = res_reg.busy_res;
    assign done_res     = res_reg.done_res;
    assign read_value   = res_reg.read_value;
    assign read_raw     = res_reg.read_raw;

endmodule

/* rtl/core/twsmb_checker.sv */
// Port-level checker for three_wire_serial_master_bcd, with its bind.
// Depends only on the top level's ports.
module twsmb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        chip_enable,
    input logic        serial_clock,
    input logic        data_drive,
    input logic        busy_res,
    input logic        done_res,
    input logic [7:0]  read_value,
    input logic [63:0] read_raw
);

    // Every accepted input beat leaves a result beat pending on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // The done tick has chip enable low and the bus released.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !chip_enable && !busy_res && !data_drive
                                  && !serial_clock)
        else $error("done tick with bus still active");

    // Clock pulses and data driving happen only inside a transfer.
    a_clock_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (serial_clock || data_drive) |-> chip_enable && busy_res)
        else $error("bus activity outside a transfer");

    // Read results appear only on the done tick.
    a_results_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> read_value == 8'd0 && read_raw == 64'd0)
        else $error("read result outside the done tick");

endmodule

bind three_wire_serial_master_bcd twsmb_checker u_twsmb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chip_enable  (chip_enable),
    .serial_clock (serial_clock),
    .data_drive   (data_drive),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_value   (read_value),
    .read_raw     (read_raw)
);
